// ===== design/lrut_pkg.sv =====
package lrut_pkg;

  // Default geometry of the cache
  localparam int SLOTS_DEF     = 16;
  localparam int KEY_BITS_DEF  = 64;
  localparam int DATA_BITS_DEF = 32;

  // Fixed widths of the request and result fields
  localparam int REQ_W    = 2;
  localparam int KEY_W    = 64;
  localparam int PAY_W    = 32;
  localparam int IDX_W    = 4;
  localparam int CAP_W    = 5;
  localparam int STAMP_W  = 64;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic [REQ_W-1:0] {
    REQ_CONTAINS = 2'd0,
    REQ_GET      = 2'd1,
    REQ_PUT      = 2'd2,
    REQ_CLEAR    = 2'd3
  } req_t;

endpackage

// ===== design/lru_timestamp_cache.sv =====
// Fully associative cache with least-recently-used replacement by access
// stamps. A request (contains, get, put, clear) is taken when start is high
// and busy is low; its one result appears on hit, read_data, evicted and
// slot_index for exactly one cycle, marked by done, and the receiver cannot
// stall it. A clear answers at once: done follows the accepting edge.
// Any other request walks the active slots one per cycle through the read
// port of the key, payload and stamp memories and one shared key and stamp
// comparator, then resolves, and done rises as busy falls; the next request
// can be taken on the edge that ends the done cycle. The capacity register
// is written over cfg_valid/cfg_ready while idle and no request is offered
// on start; slots beyond the new capacity are dropped at once. There is no
// clearing pass after reset: the slot valid bits sit in flip-flops.
module lru_timestamp_cache
  import lrut_pkg::*;
#(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  // request channel
  input  logic             start,
  output logic             busy,
  input  logic [REQ_W-1:0] req_type,
  input  logic [KEY_W-1:0] key,
  input  logic [PAY_W-1:0] payload,
  // result strobe
  output logic             done,
  output logic             hit,
  output logic [PAY_W-1:0] read_data,
  output logic             evicted,
  output logic [IDX_W-1:0] slot_index,
  // capacity register
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CAP_W-1:0] cfg_data
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;  // slot index width
  localparam int CW = $clog2(SLOTS + 1);                // slot count width

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESOLVE
  } state_t;

  // Effective capacity: zero acts as one, anything past SLOTS as SLOTS.
  function automatic logic [CW-1:0] clamp_slots(input logic [CAP_W-1:0] a);
    logic [CW-1:0] r;
    if (a == '0) begin
      r = CW'(1);
    end else if (int'(a) > SLOTS) begin
      r = CW'(SLOTS);
    end else begin
      r = CW'(a);
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] to_index(input logic [IW-1:0] x);
    logic [IW+IDX_W-1:0] t;
    t = {{IDX_W{1'b0}}, x};
    return t[IDX_W-1:0];
  endfunction

  function automatic logic [PAY_W-1:0] to_word(input logic [DATA_BITS-1:0] d);
    logic [DATA_BITS+PAY_W-1:0] t;
    t = {{PAY_W{1'b0}}, d};
    return t[PAY_W-1:0];
  endfunction

  function automatic logic [DATA_BITS-1:0] from_word(input logic [PAY_W-1:0] w);
    logic [DATA_BITS+PAY_W-1:0] t;
    t = {{DATA_BITS{1'b0}}, w};
    return t[DATA_BITS-1:0];
  endfunction

  state_t               state;
  logic [CAP_W-1:0]     active_slots;
  logic [SLOTS-1:0]     valid;
  logic [STAMP_W-1:0]   access_count;

  // latched request
  req_t                 req;
  logic [KEY_BITS-1:0]  key_q;
  logic [DATA_BITS-1:0] data_q;
  logic [CW-1:0]        live_n;

  // scan pointer and compare stage
  logic [CW-1:0]        cnt;
  logic                 chk_on;
  logic [IW-1:0]        chk_idx;

  // scan results
  logic                 found;
  logic [IW-1:0]        hit_idx;
  logic [DATA_BITS-1:0] hit_data;
  logic                 free_found;
  logic [IW-1:0]        free_idx;
  logic                 lru_seen;
  logic [IW-1:0]        lru_idx;
  logic [STAMP_W-1:0]   lru_stamp;

  // memory ports
  logic [KEY_BITS-1:0]  key_rd;
  logic [DATA_BITS-1:0] data_rd;
  logic [STAMP_W-1:0]   stamp_rd;
  logic [IW-1:0]        rd_addr;
  logic                 fill_we;
  logic                 stamp_we;
  logic [IW-1:0]        tgt_idx;
  logic [IW-1:0]        stamp_addr;
  logic [STAMP_W-1:0]   stamp_new;

  // shared comparator outputs
  logic                 key_match;
  logic                 older;
  logic                 is_get;
  logic                 is_put;

  assign busy      = (state != ST_IDLE);
  // Hold capacity writes off while a request is offered, so a request and a
  // capacity change never land on the same edge.
  assign cfg_ready = ~busy & ~start;

  // Issue the read for the slot under the pointer; its registered data lands in the following cycle.
  assign rd_addr    = cnt[IW-1:0];
  assign is_get     = (req == REQ_GET);
  assign is_put     = (req == REQ_PUT);
  // A put miss goes to the lowest free slot, else over the oldest entry.
  assign tgt_idx    = free_found ? free_idx : lru_idx;
  assign stamp_addr = found ? hit_idx : tgt_idx;
  assign stamp_new  = access_count + STAMP_W'(1);
  assign fill_we    = (state == ST_RESOLVE) && is_put && !found;
  assign stamp_we   = (state == ST_RESOLVE) && (is_put || (is_get && found));

  always_comb begin
    key_match = valid[chk_idx] && (key_rd == key_q);
    older     = stamp_rd < lru_stamp;
  end

  lrut_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS), .AW(IW)) u_key_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (tgt_idx),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lrut_ram #(.WIDTH(DATA_BITS), .DEPTH(SLOTS), .AW(IW)) u_data_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (tgt_idx),
    .wdata (data_q),
    .raddr (rd_addr),
    .rdata (data_rd)
  );

  lrut_ram #(.WIDTH(STAMP_W), .DEPTH(SLOTS), .AW(IW)) u_stamp_ram (
    .clk   (clk),
    .we    (stamp_we),
    .waddr (stamp_addr),
    .wdata (stamp_new),
    .raddr (rd_addr),
    .rdata (stamp_rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      active_slots <= CAP_RESET;
      valid        <= '0;
      access_count <= '0;
      cnt          <= '0;
      chk_on       <= 1'b0;
      done         <= 1'b0;
      hit          <= 1'b0;
      read_data    <= '0;
      evicted      <= 1'b0;
      slot_index   <= '0;
    end else begin
      done <= 1'b0;

      // Capacity write: drop every slot at or beyond the new capacity.
      if (cfg_valid && cfg_ready) begin
        active_slots <= cfg_data;
        for (int i = 0; i < SLOTS; i++) begin
          if (i >= int'(clamp_slots(cfg_data))) begin
            valid[i] <= 1'b0;
          end
        end
      end

      // Compare stage: first match, first free slot, oldest valid entry.
      // Strict less-than keeps the lowest index on a stamp tie.
      if (chk_on) begin
        if (!found && key_match) begin
          found    <= 1'b1;
          hit_idx  <= chk_idx;
          hit_data <= data_rd;
        end
        if (!free_found && !valid[chk_idx]) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if (valid[chk_idx] && (!lru_seen || older)) begin
          lru_seen  <= 1'b1;
          lru_idx   <= chk_idx;
          lru_stamp <= stamp_rd;
        end
      end

      case (state)
        ST_IDLE: begin
          if (start) begin
            req        <= req_t'(req_type);
            key_q      <= key[KEY_BITS-1:0];
            data_q     <= from_word(payload);
            live_n     <= clamp_slots(active_slots);
            cnt        <= '0;
            chk_on     <= 1'b0;
            found      <= 1'b0;
            free_found <= 1'b0;
            lru_seen   <= 1'b0;
            if (req_t'(req_type) == REQ_CLEAR) begin
              // Empty every slot, keep the counter, answer at once.
              valid      <= '0;
              hit        <= 1'b0;
              read_data  <= '0;
              evicted    <= 1'b0;
              slot_index <= '0;
              done       <= 1'b1;
            end else begin
              state <= ST_SCAN;
            end
          end
        end

        ST_SCAN: begin
          if (cnt != live_n) begin
            cnt     <= cnt + CW'(1);
            chk_on  <= 1'b1;
            chk_idx <= cnt[IW-1:0];
          end else begin
            // last slot is compared on this edge
            chk_on <= 1'b0;
            state  <= ST_RESOLVE;
          end
        end

        ST_RESOLVE: begin
          hit       <= found;
          read_data <= (found && is_get) ? to_word(hit_data) : '0;
          evicted   <= is_put && !found && !free_found;
          if (found) begin
            slot_index <= to_index(hit_idx);
          end else if (is_put) begin
            slot_index <= to_index(tgt_idx);
          end else begin
            slot_index <= '0;
          end

          // Advance the counter: once on a get hit or put miss, twice on a put hit.
          if (found && is_put) begin
            access_count <= access_count + STAMP_W'(2);
          end else if (found && is_get) begin
            access_count <= access_count + STAMP_W'(1);
          end else if (is_put) begin
            access_count <= access_count + STAMP_W'(1);
          end

          if (fill_we) begin
            valid[tgt_idx] <= 1'b1;
          end

          done  <= 1'b1;
          state <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A result is only ever strobed once the sequencer has let go.
  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while busy");

  // Eviction belongs to a reported put miss.
  a_evict_miss : assert property (@(posedge clk) disable iff (rst)
    (done && evicted) |-> !hit)
    else $error("eviction reported without a miss result");

  // Any accepted lookup request holds the block busy on the next cycle.
  a_scan_busy : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type != REQ_CLEAR)) |=> busy)
    else $error("lookup request accepted without starting a scan");

  // A clear answers on the very next cycle with an empty result.
  a_clear_done : assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == REQ_CLEAR)) |=> (done && !hit && !evicted))
    else $error("clear did not answer at once");

endmodule

// ===== design/lrut_ram.sv =====
module lrut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== tb/testbench.sv =====
module testbench;
  import lrut_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam int POOL  = 28;

  // Clock, reset and every block input start at known values
  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  logic [REQ_W-1:0] req_type  = '0;
  logic [KEY_W-1:0] key       = '0;
  logic [PAY_W-1:0] payload   = '0;
  logic             cfg_valid = 1'b0;
  logic [CAP_W-1:0] cfg_data  = '0;
  logic             busy;
  logic             done;
  logic             hit;
  logic [PAY_W-1:0] read_data;
  logic             evicted;
  logic [IDX_W-1:0] slot_index;
  logic             cfg_ready;

  typedef struct packed {
    logic             hit;
    logic [PAY_W-1:0] read_data;
    logic             evicted;
    logic [IDX_W-1:0] slot_index;
  } lookup_result_t;

  // Shadow copy of the cache contents, the access counter and the capacity
  logic               cached_valid [SLOTS];
  logic [KEY_W-1:0]   cached_key   [SLOTS];
  logic [PAY_W-1:0]   cached_data  [SLOTS];
  logic [STAMP_W-1:0] cached_stamp [SLOTS];
  logic [STAMP_W-1:0] use_counter;
  logic [CAP_W-1:0]   capacity_setting;

  // Outcomes of accepted requests, oldest first, awaiting their done strobe
  lookup_result_t predicted_lookups [$];

  logic [KEY_W-1:0] key_pool [POOL];
  int sender_idle_pct = 0;
  int mismatch_count  = 0;
  int request_count   = 0;
  int result_count    = 0;
  int hit_count       = 0;
  int evict_count     = 0;
  int capacity_writes = 0;

  lru_timestamp_cache dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .key        (key),
    .payload    (payload),
    .done       (done),
    .hit        (hit),
    .read_data  (read_data),
    .evicted    (evicted),
    .slot_index (slot_index),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // A capacity of zero behaves as one slot, anything above SLOTS as SLOTS
  function automatic int effective_capacity();
    if (capacity_setting == 0) return 1;
    if (capacity_setting > SLOTS) return SLOTS;
    return int'(capacity_setting);
  endfunction

  // Work out the result of one request and advance the shadow state with it
  function automatic lookup_result_t cache_access_outcome(req_t op,
      logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
    lookup_result_t res;
    int live;
    int found;
    int target;
    res = '0;
    live = effective_capacity();
    if (op == REQ_CLEAR) begin
      // Empty every slot; the counter carries on
      for (int i = 0; i < SLOTS; i++) cached_valid[i] = 1'b0;
      return res;
    end
    // Lowest matching slot among the live ones wins
    found = -1;
    for (int i = 0; i < live; i++)
      if (found < 0 && cached_valid[i] && cached_key[i] == k) found = i;
    if (found >= 0) begin
      res.hit = 1'b1;
      res.slot_index = IDX_W'(found);
      if (op == REQ_GET) begin
        use_counter++;
        cached_stamp[found] = use_counter;
        res.read_data = cached_data[found];
      end else if (op == REQ_PUT) begin
        // Refresh as a get would, keep the old payload, bump the counter twice
        use_counter++;
        cached_stamp[found] = use_counter;
        use_counter++;
      end
    end else if (op == REQ_PUT) begin
      use_counter++;
      target = -1;
      for (int i = 0; i < live; i++)
        if (target < 0 && !cached_valid[i]) target = i;
      if (target < 0) begin
        // Full: replace the oldest stamp, lowest index on a tie
        target = 0;
        for (int i = 1; i < live; i++)
          if (cached_stamp[i] < cached_stamp[target]) target = i;
        res.evicted = 1'b1;
      end
      cached_valid[target] = 1'b1;
      cached_key[target]   = k;
      cached_data[target]  = p;
      cached_stamp[target] = use_counter;
      res.slot_index = IDX_W'(target);
    end
    return res;
  endfunction

  // Present one request, holding it until the block takes it. Idle gaps of
  // random length may go in front, so start can rise at any point of a busy spell.
  task automatic issue_request(input req_t op, input logic [KEY_W-1:0] k,
      input logic [PAY_W-1:0] p);
    int gap;
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      gap = ($urandom_range(3) == 0) ? $urandom_range(5, 24) : $urandom_range(1, 4);
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start    <= 1'b1;
    req_type <= op;
    key      <= k;
    payload  <= p;
    do @(posedge clk); while (busy !== 1'b0);
    predicted_lookups.push_back(cache_access_outcome(op, k, p));
    request_count++;
  endtask

  // Drop start and hold until every outstanding request has reported back
  task automatic await_idle();
    @(negedge clk);
    start <= 1'b0;
    while (predicted_lookups.size() != 0) @(posedge clk);
  endtask

  // Write the capacity register once the cache is idle; slots beyond the
  // new capacity are lost straight away
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    int live;
    await_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    capacity_setting = value;
    live = effective_capacity();
    for (int i = live; i < SLOTS; i++) cached_valid[i] = 1'b0;
    capacity_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Misses on an empty cache, extreme keys and payloads, hits of every kind,
  // a put hit that must not replace the payload, and clear
  task automatic test_basic_requests();
    issue_request(REQ_CONTAINS, '0, '0);
    issue_request(REQ_GET, '0, 32'h1234_5678);
    issue_request(REQ_PUT, '0, '0);
    issue_request(REQ_PUT, '1, '1);
    issue_request(REQ_CONTAINS, '1, '0);
    issue_request(REQ_GET, '1, '0);
    issue_request(REQ_GET, '0, '1);
    issue_request(REQ_PUT, '0, 32'hdead_beef);
    issue_request(REQ_GET, '0, '0);
    issue_request(REQ_CLEAR, '1, '1);
    issue_request(REQ_CONTAINS, '1, '0);
    issue_request(REQ_PUT, 64'h0123_4567_89ab_cdef, 32'ha5a5_5a5a);
  endtask

  // Two slots: a get refreshes the first entry, so the second is the one replaced
  task automatic test_replacement_order();
    write_capacity(5'd2);
    issue_request(REQ_PUT, 64'hffff_0000_ffff_0000, 32'h0000_0001);
    issue_request(REQ_PUT, 64'h0000_ffff_0000_ffff, 32'h0000_0002);
    issue_request(REQ_GET, 64'hffff_0000_ffff_0000, '0);
    issue_request(REQ_PUT, 64'h5555_5555_5555_5555, 32'h0000_0003);
    issue_request(REQ_CONTAINS, 64'h0000_ffff_0000_ffff, '0);
  endtask

  // Zero acts as one slot, an oversize value as full size, and shrinking
  // discards entries above the new limit
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    issue_request(REQ_PUT, 64'haaaa_aaaa_aaaa_aaaa, 32'h1111_1111);
    issue_request(REQ_PUT, 64'h8000_0000_0000_0001, 32'h2222_2222);
    write_capacity(5'd31);
    issue_request(REQ_PUT, 64'h7fff_ffff_ffff_fffe, 32'h3333_3333);
    write_capacity(5'd1);
    issue_request(REQ_CONTAINS, 64'h7fff_ffff_ffff_fffe, '0);
    issue_request(REQ_GET, 64'h8000_0000_0000_0001, '0);
  endtask

  // Mostly puts and lookups over a small key set so hits and evictions are
  // common, a sprinkle of fresh keys and clears, across capacities and idling
  task automatic test_random_traffic();
    int phase_idle [4];
    int capacities [16];
    int pick;
    int span;
    req_t op;
    logic [KEY_W-1:0] k;
    phase_idle = '{0, 46, 0, 36};
    capacities = '{16, 3, 0, 31, 8, 1, 17, 16, 5, 16, 2, 31, 12, 0, 16, 7};
    for (int i = 0; i < POOL; i++) key_pool[i] = {$urandom, $urandom};
    for (int ph = 0; ph < 4; ph++) begin
      for (int c = 0; c < 4; c++) begin
        write_capacity(CAP_W'(capacities[ph * 4 + c]));
        sender_idle_pct = phase_idle[ph];
        span = effective_capacity() + effective_capacity() / 2 + 1;
        if (span > POOL - 1) span = POOL - 1;
        for (int n = 0; n < 56; n++) begin
          pick = $urandom_range(99);
          if (pick < 42) op = REQ_PUT;
          else if (pick < 72) op = REQ_GET;
          else if (pick < 98) op = REQ_CONTAINS;
          else op = REQ_CLEAR;
          if ($urandom_range(9) == 0) k = {$urandom, $urandom};
          else k = key_pool[$urandom_range(span)];
          issue_request(op, k, $urandom);
        end
        sender_idle_pct = 0;
      end
    end
  endtask

  // Check each strobed result against the oldest outstanding prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && done) begin
      if (predicted_lookups.size() == 0) begin
        $error("result with no request outstanding: hit %0b slot %0d", hit, slot_index);
        mismatch_count++;
      end else begin
        want = predicted_lookups.pop_front();
        result_count++;
        if (hit) hit_count++;
        if (evicted) evict_count++;
        if (hit !== want.hit) begin
          $error("hit: expected %0b, got %0b", want.hit, hit);
          mismatch_count++;
        end
        if (read_data !== want.read_data) begin
          $error("read_data: expected %h, got %h", want.read_data, read_data);
          mismatch_count++;
        end
        if (evicted !== want.evicted) begin
          $error("evicted: expected %0b, got %0b", want.evicted, evicted);
          mismatch_count++;
        end
        if (slot_index !== want.slot_index) begin
          $error("slot_index: expected %0d, got %0d", want.slot_index, slot_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      cached_valid[i] = 1'b0;
      cached_key[i]   = '0;
      cached_data[i]  = '0;
      cached_stamp[i] = '0;
    end
    use_counter      = '0;
    capacity_setting = CAP_RESET;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_basic_requests();
    test_replacement_order();
    test_capacity_limits();
    test_random_traffic();

    // Let the last results drain, then allow one full slot walk for stragglers
    await_idle();
    repeat (SLOTS + 8) @(posedge clk);
    $display("Checked %0d results for %0d requests: %0d hits, %0d evictions",
             result_count, request_count, hit_count, evict_count);
    $display("Capacity written %0d times, sender idling off, at 46%% and at 36%%",
             capacity_writes);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5_000_000;
    $display("Timeout waiting on the cache");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
design/lrut_pkg.sv
design/lrut_ram.sv
design/lru_timestamp_cache.sv
tb/testbench.sv
